// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when pre holds, post must hold at the same edge.
`define YT_ASSERT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication: when pre holds, post must hold at the next edge.
`define YT_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- design/ytpq_pkg.sv -----
// ---------------------------------------------------------------------------
// Young tableau priority queue package
// Sizes, codes, control structs and cell helper functions.
// ---------------------------------------------------------------------------
`default_nettype none

package ytpq_pkg;

  // Table geometry and key width.
  localparam int SIDE     = 4;
  localparam int KEY_BITS = 16;
  localparam int NCELLS   = SIDE * SIDE;
  localparam int CELL_W   = $clog2(NCELLS);
  localparam int POS_W    = $clog2(SIDE);

  // Fixed widths of the channel fields.
  localparam int IO_KEY_W = 16;
  localparam int STATUS_W = 2;

  // Operation codes carried in the mode field.
  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [CELL_W-1:0]   cell_t;
  typedef logic [POS_W-1:0]    pos_t;

  localparam pos_t POS_LAST = pos_t'(SIDE - 1);

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load_ext;
    logic sift;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_ok;
    logic start_ext;
    logic sift_done;
    logic corner_zero;
  } sts_t;

  // Row-major cell index of a row and column.
  function automatic cell_t cell_idx(pos_t r, pos_t c);
    return cell_t'(cell_t'(r) * cell_t'(SIDE) + cell_t'(c));
  endfunction

  // Occupied cell with the largest row+column sum, highest row on a tie.
  // Later hits override earlier ones, so the scan runs in rising priority.
  function automatic cell_t find_corner(logic [NCELLS-1:0] occ);
    int    c;
    cell_t idx;
    idx = '0;
    for (int s = 0; s <= 2 * (SIDE - 1); s++) begin
      for (int r = 0; r < SIDE; r++) begin
        c = s - r;
        if (c >= 0 && c < SIDE) begin
          if (occ[r * SIDE + c]) begin
            idx = cell_t'(r * SIDE + c);
          end
        end
      end
    end
    return idx;
  endfunction

  // Key field of the channel to an internal key: upper bits are dropped.
  function automatic key_t key_from_io(logic [IO_KEY_W-1:0] k);
    logic [KEY_BITS+IO_KEY_W-1:0] w;
    w = {{KEY_BITS{1'b0}}, k};
    return w[KEY_BITS-1:0];
  endfunction

  // Internal key to the channel's key field.
  function automatic logic [IO_KEY_W-1:0] key_to_io(key_t k);
    logic [KEY_BITS+IO_KEY_W-1:0] w;
    w = {{IO_KEY_W{1'b0}}, k};
    return w[IO_KEY_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- design/ytpq_if.sv -----
// ---------------------------------------------------------------------------
// Young tableau priority queue channels
// Valid/ready request and response channels of the queue.
// ---------------------------------------------------------------------------
`default_nettype none

// Request channel: one operation per beat.
interface ytpq_in_if;
  import ytpq_pkg::*;

  logic                valid;
  logic                ready;
  logic                mode;
  logic [IO_KEY_W-1:0] key;

  modport source (output valid, output mode, output key, input ready);
  modport sink (input valid, input mode, input key, output ready);
endinterface

// Response channel: one result per operation.
interface ytpq_out_if;
  import ytpq_pkg::*;

  logic                valid;
  logic                ready;
  logic [IO_KEY_W-1:0] popped_key;
  logic [STATUS_W-1:0] status;
  logic                now_empty;
  logic                now_full;

  modport source (output valid, output popped_key, output status, output now_empty,
                  output now_full, input ready);
  modport sink (input valid, input popped_key, input status, input now_empty,
                input now_full, output ready);
endinterface

`default_nettype wire

// ----- design/ytpq_ctrl.sv -----
// ---------------------------------------------------------------------------
// Young tableau priority queue controller
// Sequences accept, extract load, sift steps and result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module ytpq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  ytpq_pkg::sts_t sts_i,
  output ytpq_pkg::cmd_t cmd_o
);
  import ytpq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOAD   = 4'b0010,
    S_SIFT   = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and command decode.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (!sts_i.start_ok) begin
            state_d = S_FINISH;
          end else if (sts_i.start_ext) begin
            state_d = S_LOAD;
          end else begin
            state_d = S_SIFT;
          end
        end
      end
      S_LOAD: begin
        cmd_o.load_ext = 1'b1;
        state_d        = sts_i.corner_zero ? S_FINISH : S_SIFT;
      end
      S_SIFT: begin
        cmd_o.sift = 1'b1;
        if (sts_i.sift_done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        // The result register is free or is being emptied this cycle.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and result-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/ytpq_dpath.sv -----
// ---------------------------------------------------------------------------
// Young tableau priority queue datapath
// Cell key memory, occupancy flags, moving key and one compare-swap a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ytpq_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_mode_i,
  input  logic [ytpq_pkg::IO_KEY_W-1:0]    in_key_i,
  input  ytpq_pkg::cmd_t                   cmd_i,
  output ytpq_pkg::sts_t                   sts_o,
  output logic [ytpq_pkg::IO_KEY_W-1:0]    out_popped_key_o,
  output ytpq_pkg::status_e                out_status_o,
  output logic                             out_now_empty_o,
  output logic                             out_now_full_o
);
  import ytpq_pkg::*;

  // A cell value with the empty flag above the key: empty beats any key.
  typedef logic [KEY_BITS:0] val_t;
  localparam val_t VAL_EMPTY = {1'b1, {KEY_BITS{1'b0}}};

  // One step toward a neighbor, held at the table edge.
  function automatic pos_t step_pos(pos_t p, logic down);
    pos_t r;
    if (down) begin
      r = (p == POS_LAST) ? p : p + pos_t'(1);
    end else begin
      r = (p == '0) ? p : p - pos_t'(1);
    end
    return r;
  endfunction

  // Cell keys: vertical and horizontal neighbor read ports, one write port.
  key_t  mem [NCELLS];
  key_t  rd_v_q, rd_h_q;
  cell_t rd_v_addr, rd_h_addr;
  logic  wr_en;
  cell_t wr_addr;
  key_t  wr_data;

  logic [NCELLS-1:0] occ_q, occ_d;
  key_t              key_q, key_d;
  pos_t              row_q, row_d, col_q, col_d;
  logic              down_q, down_d;
  key_t              popped_q, popped_d;
  status_e           status_q, status_d;
  logic              corner_zero_q, corner_zero_d;

  logic  is_ins, is_full, is_empty;
  cell_t cell_last, corner, cur_cell, v_cell, h_cell, cand_cell;
  logic  has_v, has_h, go_v, move;
  val_t  cur_val, v_val, h_val, cand_val;
  key_t  cand_key;

  // Table status seen at accept.
  assign cell_last = cell_idx(POS_LAST, POS_LAST);
  assign is_full   = occ_q[cell_last];
  assign is_empty  = !occ_q[0];
  assign corner    = find_corner(occ_q);
  assign is_ins    = (in_mode_i == MODE_INSERT);

  // Compare of the moving key against its neighbors on the sift path.
  always_comb begin
    has_v    = down_q ? (row_q != POS_LAST) : (row_q != '0);
    has_h    = down_q ? (col_q != POS_LAST) : (col_q != '0);
    cur_cell = cell_idx(row_q, col_q);
    v_cell   = cell_idx(step_pos(row_q, down_q), col_q);
    h_cell   = cell_idx(row_q, step_pos(col_q, down_q));
    cur_val  = {1'b0, key_q};
    v_val    = occ_q[v_cell] ? {1'b0, rd_v_q} : VAL_EMPTY;
    h_val    = occ_q[h_cell] ? {1'b0, rd_h_q} : VAL_EMPTY;
    if (has_v && has_h) begin
      go_v = down_q ? (v_val <= h_val) : (v_val >= h_val);
    end else begin
      go_v = has_v;
    end
    cand_cell = go_v ? v_cell : h_cell;
    cand_val  = go_v ? v_val : h_val;
    cand_key  = go_v ? rd_v_q : rd_h_q;
    move      = (has_v || has_h) && (down_q ? (cur_val > cand_val) : (cur_val < cand_val));
  end

  assign sts_o.start_ok    = is_ins ? !is_full : !is_empty;
  assign sts_o.start_ext   = !is_ins;
  assign sts_o.sift_done   = !move;
  assign sts_o.corner_zero = corner_zero_q;

  // Operation state updates.
  always_comb begin
    occ_d         = occ_q;
    key_d         = key_q;
    row_d         = row_q;
    col_d         = col_q;
    down_d        = down_q;
    popped_d      = popped_q;
    status_d      = status_q;
    corner_zero_d = corner_zero_q;
    wr_en         = 1'b0;
    wr_addr       = cur_cell;
    wr_data       = key_q;

    if (cmd_i.accept) begin
      status_d = ST_DONE;
      popped_d = '0;
      if (is_ins) begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          // New key enters at the bottom-right cell and rises from there.
          occ_d[cell_last] = 1'b1;
          key_d            = key_from_io(in_key_i);
          row_d            = POS_LAST;
          col_d            = POS_LAST;
          down_d           = 1'b0;
        end
      end else begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          // The corner key leaves its cell and will refill the top-left cell.
          occ_d[corner] = 1'b0;
          corner_zero_d = (corner == '0);
        end
      end
    end

    if (cmd_i.load_ext) begin
      popped_d = rd_v_q;
      key_d    = rd_h_q;
      row_d    = '0;
      col_d    = '0;
      down_d   = 1'b1;
    end

    if (cmd_i.sift) begin
      wr_en = 1'b1;
      if (move) begin
        // The neighbor takes the current cell and the moving key steps on.
        // The occupied flags swap as well, so a key rising into an empty
        // cell leaves an empty cell behind it.
        wr_data          = cand_key;
        occ_d[cur_cell]  = occ_q[cand_cell];
        occ_d[cand_cell] = occ_q[cur_cell];
        if (go_v) begin
          row_d = step_pos(row_q, down_q);
        end else begin
          col_d = step_pos(col_q, down_q);
        end
      end else begin
        wr_data = key_q;
      end
    end
  end

  // Read addresses: the top-left and corner cells on extract accept,
  // otherwise the neighbors of the next sift position.
  always_comb begin
    if (cmd_i.accept && !is_ins) begin
      rd_v_addr = '0;
      rd_h_addr = corner;
    end else begin
      rd_v_addr = cell_idx(step_pos(row_d, down_d), col_d);
      rd_h_addr = cell_idx(row_d, step_pos(col_d, down_d));
    end
  end

  // Cell key memory.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_v_q <= mem[rd_v_addr];
    rd_h_q <= mem[rd_h_addr];
  end

  // Occupancy flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // Working registers of the current operation.
  always_ff @(posedge clk_i) begin
    key_q         <= key_d;
    row_q         <= row_d;
    col_q         <= col_d;
    down_q        <= down_d;
    popped_q      <= popped_d;
    status_q      <= status_d;
    corner_zero_q <= corner_zero_d;
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_popped_key_o <= key_to_io(popped_q);
      out_status_o     <= status_q;
      out_now_empty_o  <= !occ_q[0];
      out_now_full_o   <= occ_q[cell_last];
    end
  end

endmodule

`default_nettype wire

// ----- design/young_tableau_priority_queue_core.sv -----
// ---------------------------------------------------------------------------
// Young tableau priority queue core
// Min-priority queue held as a SIDE x SIDE sorted table of keys.
// ---------------------------------------------------------------------------
// Usage:
// A request beat on in_i carries mode (insert or extract) and key. One result
// beat on out_o follows each request: popped_key, status, now_empty, now_full.
// An insert into a full table is dropped with status full; an extract from an
// empty table returns zero with status empty. Both pass from the accept step
// straight to the result step. An insert has an accept step, sift steps and
// a result step; an extract adds a load step to read the top-left and corner
// cells, and skips the sift when the corner is the top-left cell. Each sift
// cycle is one compare-swap through the two read ports of the cell key memory.
// The result is valid the cycle after the result cycle and in_i.ready rises
// again at that time, so the next request can be taken while it waits.
// When the receiver stalls, the result stays in the output register and the
// following operation holds in its result cycle until the register is freed.
// Reset empties the table and clears any pending result.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module young_tableau_priority_queue_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  ytpq_in_if.sink     in_i,
  ytpq_out_if.source  out_o
);
  import ytpq_pkg::*;

  cmd_t    cmd;
  sts_t    sts;
  status_e out_status;

  ytpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ytpq_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mode_i        (in_i.mode),
    .in_key_i         (in_i.key),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_popped_key_o (out_o.popped_key),
    .out_status_o     (out_status),
    .out_now_empty_o  (out_o.now_empty),
    .out_now_full_o   (out_o.now_full)
  );

  assign out_o.status = out_status;

  // An accepted beat moves the controller out of idle, which drops in_i.ready.
  `YT_ASSERT_NXT(a_busy_after_beat, in_i.valid && in_i.ready, !in_i.ready, "beat taken while busy")

  // A dropped insert leaves the table full.
  `YT_ASSERT(a_drop_when_full, out_o.valid && (out_o.status == ST_FULL), out_o.now_full, "drop not full")

  // An extract on an empty table reports zero and an empty table.
  `YT_ASSERT(a_empty_extract, out_o.valid && (out_o.status == ST_EMPTY), out_o.now_empty && (out_o.popped_key == '0), "bad empty extract")

  // Loading the result register always raises the result valid.
  `YT_ASSERT_NXT(a_result_shown, cmd.out_load, out_o.valid, "result not shown")

endmodule

`default_nettype wire
